[sv/jsbs_pkg.sv]
// Shared types, character codes and default sizes for the JSON structural bracket scanner.
`default_nettype none

package jsbs_pkg;

	localparam int MAX_DEPTH_DEF   = 64;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int OUT_CNT_W       = 16;
	localparam int OUT_DEPTH_W     = 7;

	localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;

	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_LBRACK    = 8'h5B;
	localparam logic [7:0] CH_RBRACK    = 8'h5D;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_COMMA     = 8'h2C;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_SEP         = 3'd1,
		EV_OK          = 3'd2,
		EV_MISMATCH    = 3'd3,
		EV_NOT_BRACKET = 3'd4,
		EV_UNTERM      = 3'd5,
		EV_OVERFLOW    = 3'd6
	} event_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		event_t                   event_res;
		logic [OUT_CNT_W-1:0]     element_count;
		logic [OUT_CNT_W-1:0]     byte_offset;
		logic [OUT_DEPTH_W-1:0]   nesting_depth;
	} out_item_t;

endpackage

`default_nettype wire

[sv/jsbs_core.sv]
// Scan state registers and the per-byte update logic of the JSON structural bracket scanner.
`default_nettype none

module jsbs_core #(
	parameter int MAX_DEPTH   = jsbs_pkg::MAX_DEPTH_DEF,
	parameter int COUNT_WIDTH = jsbs_pkg::COUNT_WIDTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step,
	input  jsbs_pkg::in_item_t  item,
	output jsbs_pkg::out_item_t result
);
	import jsbs_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam logic [DW-1:0]          DEPTH_LIMIT = DW'(MAX_DEPTH);
	localparam logic [DW-1:0]          DEPTH_ONE   = DW'(1);
	localparam logic [COUNT_WIDTH-1:0] SEP_MAX     = '1;

	logic                   in_str_q, in_str_d;
	logic                   esc_q, esc_d;
	logic [DW-1:0]          depth_q, depth_d;
	logic                   is_obj_q, is_obj_d;
	logic                   active_q, active_d;
	logic [COUNT_WIDTH-1:0] sep_q, sep_d;
	logic                   content_q, content_d;
	logic [OUT_CNT_W-1:0]   offset_q, offset_d;
	event_t                 ev;
	logic [COUNT_WIDTH:0]   elem_wide;
	logic [OUT_CNT_W-1:0]   elem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_str_q  <= 1'b0;
			esc_q     <= 1'b0;
			depth_q   <= '0;
			is_obj_q  <= 1'b0;
			active_q  <= 1'b0;
			sep_q     <= '0;
			content_q <= 1'b0;
			offset_q  <= '0;
		end else if (step) begin
			in_str_q  <= in_str_d;
			esc_q     <= esc_d;
			depth_q   <= depth_d;
			is_obj_q  <= is_obj_d;
			active_q  <= active_d;
			sep_q     <= sep_d;
			content_q <= content_d;
			offset_q  <= offset_d;
		end
	end

	always_comb begin
		logic [7:0] b;
		logic       ended;
		b         = item.data_byte;
		ended     = 1'b0;
		in_str_d  = in_str_q;
		esc_d     = esc_q;
		depth_d   = depth_q;
		is_obj_d  = is_obj_q;
		active_d  = active_q;
		sep_d     = sep_q;
		content_d = content_q;
		offset_d  = offset_q;
		ev        = EV_NONE;

		if (item.first_byte) begin
			in_str_d  = 1'b0;
			esc_d     = 1'b0;
			depth_d   = '0;
			is_obj_d  = 1'b0;
			active_d  = 1'b0;
			sep_d     = '0;
			content_d = 1'b0;
			offset_d  = '0;
			if (b inside {CH_LBRACE, CH_LBRACK}) begin
				active_d = 1'b1;
				is_obj_d = (b == CH_LBRACE);
				depth_d  = DEPTH_ONE;
			end else begin
				ev = EV_NOT_BRACKET;
			end
		end else if (active_q) begin
			if (offset_q != OUT_CNT_MAX) begin
				offset_d = offset_q + 1'b1;
			end
			if (esc_q) begin
				esc_d = 1'b0;
			end else if (in_str_q) begin
				if (b == CH_QUOTE) begin
					in_str_d = 1'b0;
				end else if (b == CH_BACKSLASH) begin
					esc_d = 1'b1;
				end
			end else if (b == CH_QUOTE) begin
				in_str_d = 1'b1;
			end else if (b inside {CH_LBRACE, CH_LBRACK}) begin
				if (depth_q >= DEPTH_LIMIT) begin
					active_d = 1'b0;
					ev       = EV_OVERFLOW;
					ended    = 1'b1;
				end else begin
					depth_d = depth_q + 1'b1;
				end
			end else if (b inside {CH_RBRACE, CH_RBRACK}) begin
				if (depth_q != '0) begin
					depth_d = depth_q - 1'b1;
				end
				if (depth_d == '0) begin
					// The outermost bracket closes: it must match the opening one.
					active_d = 1'b0;
					ended    = 1'b1;
					ev       = ((b == CH_RBRACE) == is_obj_q) ? EV_OK : EV_MISMATCH;
				end
			end else if (b == CH_COMMA && depth_q == DEPTH_ONE) begin
				if (sep_q != SEP_MAX) begin
					sep_d = sep_q + 1'b1;
				end
				ev = EV_SEP;
			end
			if (!ended) begin
				content_d = 1'b1;
			end
		end

		if (item.last_byte && active_d) begin
			active_d = 1'b0;
			ev       = EV_UNTERM;
		end
	end

	// Elements: zero until a byte follows the opening bracket, else separators+1, saturating.
	always_comb begin
		elem_wide = {1'b0, sep_d} + 1'b1;
		if (sep_d == SEP_MAX) begin
			elem_wide = {1'b0, sep_d};
		end
		if (!content_d) begin
			elem = '0;
		end else if (33'(elem_wide) > 33'(OUT_CNT_MAX)) begin
			elem = OUT_CNT_MAX;
		end else begin
			elem = OUT_CNT_W'(elem_wide);
		end
	end

	assign result.event_res     = ev;
	assign result.element_count = elem;
	assign result.byte_offset   = offset_d;
	assign result.nesting_depth = OUT_DEPTH_W'(depth_d);

endmodule

`default_nettype wire

[sv/json_structural_bracket_scanner.sv]
// Top level of the JSON structural bracket scanner: input register, scan core and result register.
//
// The block takes one byte of a JSON text per beat on the input channel (in_valid, in_ready,
// in_data) and returns exactly one result beat per input beat on the output channel
// (out_valid, out_ready, out_data). A byte with first_byte set restarts the scan and must be
// an opening brace or bracket; the result reports separators, the closing check, errors, the
// running element count, the offset from the opening bracket and the nesting depth.
// The accepted byte waits in the input register; when it advances, the scan state is updated and
// the result is captured in the output register, from which the result beat is taken.
// Throughput is one byte per cycle while the receiver does not stall, set by the per-byte scan update.
// in_ready stays high while the output register is empty or being drained, so bytes stream
// back to back. When the receiver stalls, the result is held in the output register, the
// byte behind it waits in the input register and in_ready falls; nothing is lost.
// Reset clears both pipeline valid flags and all scan state, leaving no scan in progress.
`default_nettype none

module json_structural_bracket_scanner #(
	parameter int MAX_DEPTH   = jsbs_pkg::MAX_DEPTH_DEF,
	parameter int COUNT_WIDTH = jsbs_pkg::COUNT_WIDTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  jsbs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output jsbs_pkg::out_item_t out_data
);
	import jsbs_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t result_s2;
	out_item_t result;
	logic      advance;

	// The byte in the input register moves on when the result register is free or draining.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	jsbs_core #(
		.MAX_DEPTH   (MAX_DEPTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

`default_nettype wire
